/* rtl/core/block_table_heap_allocator_defines.svh */
// Assertion macros shared by the heap allocator RTL.
// Macros expect clk and rst_n in scope of the including module.
`ifndef BLOCK_TABLE_HEAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_TABLE_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BTH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bth_pkg.sv */
// Package for the block table heap allocator: codes, widths, flag layout.
// No dependencies.
`default_nettype none

package bth_pkg;

  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned BIU_W           = 11;
  localparam int unsigned ACC_W           = 33;
  localparam int unsigned IN_DATA_W       = 64;
  localparam int unsigned DEF_NUM_BLOCKS  = 1024;
  localparam int unsigned DEF_BLOCK_BYTES = 4096;

  localparam int unsigned FLAG_TAKEN = 0;
  localparam int unsigned FLAG_FIRST = 1;
  localparam int unsigned FLAG_NEXT  = 2;

  typedef logic [2:0] flags_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOMEM   = 2'd1,
    STATUS_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_HEAP_BASE     = 1'b0,
    REG_BLOCKS_IN_USE = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

/* rtl/core/block_table_heap_allocator.sv */
// First-fit block table heap allocator, top level.
// Depends on bth_pkg, bth_table and block_table_heap_allocator_defines.svh.
//
// After reset the block sweeps the flag table to zero, one entry a cycle,
// with in_tready low; configuration writes are taken at any time. An
// allocate walks the managed entries one per cycle until a free run covers
// the requested bytes, then marks the run one entry per cycle. A free first
// locates the block by stepping one block size per cycle, then clears the
// chain one entry per cycle. The single table read port sets the pace.
// A result sits in an output register, so the next item may enter while it
// waits to be taken.
`default_nettype none
`include "block_table_heap_allocator_defines.svh"

module block_table_heap_allocator #(
  parameter int unsigned NUM_BLOCKS  = bth_pkg::DEF_NUM_BLOCKS,
  parameter int unsigned BLOCK_BYTES = bth_pkg::DEF_BLOCK_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bth_pkg::IN_DATA_W-1:0]  in_tdata,   // request_bytes, free_address
  input  bth_pkg::opcode_t               in_tuser,   // opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bth_pkg::ADDR_W-1:0]     out_tdata,  // result_address
  output bth_pkg::status_t               out_tuser,  // status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  bth_pkg::reg_idx_t              cfg_index,
  input  logic [bth_pkg::ADDR_W-1:0]     cfg_data
);
  import bth_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CMP_W = (CNT_W > BIU_W) ? CNT_W : BIU_W;
  localparam logic [ACC_W-1:0]  BLK_INC  = ACC_W'(BLOCK_BYTES);
  localparam logic [ADDR_W-1:0] ADDR_INC = ADDR_W'(BLOCK_BYTES);
  localparam logic [CNT_W-1:0]  LAST_IDX = CNT_W'(NUM_BLOCKS - 1);
  localparam logic [CMP_W-1:0]  NB_CMP   = CMP_W'(NUM_BLOCKS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_LOCATE,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    start_r, start_nxt;
  logic [CNT_W-1:0]    last_r, last_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [ADDR_W-1:0]   start_addr_r, start_addr_nxt;
  logic [ADDR_W-1:0]   bytes_r, bytes_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   base_r;
  logic [BIU_W-1:0]    biu_r;

  logic [CMP_W-1:0]    biu_cmp;
  logic [CNT_W-1:0]    total;
  logic [CNT_W-1:0]    i_inc;
  logic [ACC_W-1:0]    sum;
  logic [ACC_W-1:0]    bytes_ext;
  logic                i_last;
  logic                out_free;
  logic [ADDR_W-1:0]   in_bytes;
  logic [ADDR_W-1:0]   in_addr;

  logic                tbl_we;
  logic [IDX_W-1:0]    tbl_waddr;
  flags_t              tbl_wdata;
  logic [IDX_W-1:0]    tbl_raddr;
  flags_t              tbl_rdata;

  bth_table #(
    .DEPTH (NUM_BLOCKS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign biu_cmp   = CMP_W'(biu_r);
  assign total     = (biu_cmp > NB_CMP) ? CNT_W'(NB_CMP) : CNT_W'(biu_cmp);
  assign i_inc     = i_r + 1'b1;
  assign sum       = acc_r + BLK_INC;
  assign bytes_ext = {1'b0, bytes_r};
  assign i_last    = (i_r == (total - 1'b1));
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_bytes  = in_tdata[ADDR_W-1:0];
  assign in_addr   = in_tdata[IN_DATA_W-1:ADDR_W];

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    start_nxt      = start_r;
    last_nxt       = last_r;
    acc_nxt        = acc_r;
    addr_nxt       = addr_r;
    start_addr_nxt = start_addr_r;
    bytes_nxt      = bytes_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    tbl_we         = 1'b0;
    tbl_waddr      = i_r[IDX_W-1:0];
    tbl_wdata      = '0;
    tbl_raddr      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        tbl_we = 1'b1;
        if (i_r == LAST_IDX) begin
          i_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          i_nxt = i_inc;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          i_nxt        = '0;
          acc_nxt      = '0;
          addr_nxt     = base_r;
          res_addr_nxt = '0;
          if (in_tuser == OP_ALLOC) begin
            bytes_nxt = in_bytes;
            if (in_bytes == '0 || total == '0) begin
              res_status_nxt = STATUS_NOMEM;
              state_nxt      = ST_FINISH;
            end else begin
              state_nxt = ST_SCAN;
            end
          end else begin
            bytes_nxt = in_addr - base_r;
            if (in_addr < base_r || total == '0) begin
              res_status_nxt = STATUS_OUTSIDE;
              state_nxt      = ST_FINISH;
            end else begin
              state_nxt = ST_LOCATE;
            end
          end
        end
      end

      ST_SCAN: begin
        tbl_raddr = i_inc[IDX_W-1:0];
        addr_nxt  = addr_r + ADDR_INC;
        i_nxt     = i_inc;
        if (tbl_rdata[FLAG_TAKEN]) begin
          acc_nxt = '0;
          if (i_last) begin
            res_status_nxt = STATUS_NOMEM;
            state_nxt      = ST_FINISH;
          end
        end else begin
          if (acc_r == '0) begin
            start_nxt      = i_r;
            start_addr_nxt = addr_r;
          end
          if (sum >= bytes_ext) begin
            last_nxt  = i_r;
            i_nxt     = (acc_r == '0) ? i_r : start_r;
            state_nxt = ST_MARK;
          end else begin
            acc_nxt = sum;
            if (i_last) begin
              res_status_nxt = STATUS_NOMEM;
              state_nxt      = ST_FINISH;
            end
          end
        end
      end

      ST_MARK: begin
        tbl_we                = 1'b1;
        tbl_wdata[FLAG_TAKEN] = 1'b1;
        tbl_wdata[FLAG_FIRST] = (i_r == start_r);
        tbl_wdata[FLAG_NEXT]  = (i_r != last_r);
        if (i_r == last_r) begin
          res_addr_nxt   = start_addr_r;
          res_status_nxt = STATUS_OK;
          state_nxt      = ST_FINISH;
        end else begin
          i_nxt = i_inc;
        end
      end

      ST_LOCATE: begin
        tbl_raddr = i_r[IDX_W-1:0];
        if (bytes_ext < sum) begin
          state_nxt = ST_WALK;
        end else if (i_last) begin
          res_status_nxt = STATUS_OUTSIDE;
          state_nxt      = ST_FINISH;
        end else begin
          i_nxt   = i_inc;
          acc_nxt = sum;
        end
      end

      ST_WALK: begin
        tbl_raddr = i_inc[IDX_W-1:0];
        tbl_we    = 1'b1;
        if (tbl_rdata[FLAG_NEXT] && (i_inc < total)) begin
          i_nxt = i_inc;
        end else begin
          res_status_nxt = STATUS_OK;
          state_nxt      = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      i_r          <= '0;
      out_tvalid_r <= 1'b0;
      base_r       <= '0;
      biu_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      i_r          <= i_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_HEAP_BASE:     base_r <= cfg_data;
          REG_BLOCKS_IN_USE: biu_r  <= cfg_data[BIU_W-1:0];
          default:           base_r <= base_r;
        endcase
      end
    end
    start_r      <= start_nxt;
    last_r       <= last_nxt;
    acc_r        <= acc_nxt;
    addr_r       <= addr_nxt;
    start_addr_r <= start_addr_nxt;
    bytes_r      <= bytes_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  `BTH_ASSERT_NOW(a_fail_addr_zero, out_tvalid && (out_tuser != STATUS_OK),
    out_tdata == '0, "failed transaction carries nonzero address")
  `BTH_ASSERT_NOW(a_mark_in_run, state_r == ST_MARK,
    (i_r >= start_r) && (i_r <= last_r) && (last_r < total), "mark outside run")
  `BTH_ASSERT_NOW(a_walk_in_range, state_r == ST_WALK,
    i_r < total, "free walk beyond managed entries")
  `BTH_ASSERT_NEXT(a_finish_loads_out, (state_r == ST_FINISH) && out_free,
    out_tvalid && (state_r == ST_IDLE), "finished result not presented")

endmodule

`default_nettype wire

/* rtl/core/bth_table.sv */
// Block flag table: one write port, one read port with registered data.
// Depends on bth_pkg.
`default_nettype none

module bth_table #(
  parameter int unsigned DEPTH = bth_pkg::DEF_NUM_BLOCKS,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  bth_pkg::flags_t     wdata,
  input  logic [IDX_W-1:0]    raddr,
  output bth_pkg::flags_t     rdata
);
  import bth_pkg::*;

  flags_t mem [DEPTH];
  flags_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
